/* rtl/csp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, codes and character constants of the checksummed sentence
// parser.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int MAX_BODY_LEN_DEF = 64;

  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 16;
  localparam int STAT_W  = 3;
  localparam int NFIELDS = 3;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_WAITING = 3'd0;
  localparam status_t ST_GOOD    = 3'd1;
  localparam status_t ST_FAIL    = 3'd2;
  localparam status_t ST_COO     = 3'd3;
  localparam status_t ST_HIT     = 3'd4;
  localparam status_t ST_CHA     = 3'd5;
  localparam status_t ST_DET     = 3'd6;

  typedef enum logic [4:0] {
    MODE_WAIT    = 5'b00001,
    MODE_BODY    = 5'b00010,
    MODE_HEX_HI  = 5'b00100,
    MODE_HEX_LO  = 5'b01000,
    MODE_NEWLINE = 5'b10000
  } mode_t;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_UA      = 8'd65;
  localparam logic [7:0] CH_UF      = 8'd70;
  localparam logic [7:0] CH_LA      = 8'd97;
  localparam logic [7:0] CH_LF      = 8'd102;
  localparam logic [7:0] HEX_UP_OFS = 8'd55;
  localparam logic [7:0] HEX_LO_OFS = 8'd87;

  localparam logic [23:0] ID_COO = 24'h434F4F;
  localparam logic [23:0] ID_HIT = 24'h484954;
  localparam logic [23:0] ID_CHA = 24'h434841;
  localparam logic [23:0] ID_DET = 24'h444554;

  // Bit 4 flags a character that is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd16;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      d = b - CH_ZERO;
    end else if (b >= CH_UA && b <= CH_UF) begin
      d = b - HEX_UP_OFS;
    end else if (b >= CH_LA && b <= CH_LF) begin
      d = b - HEX_LO_OFS;
    end
    return d[4:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/checksummed_sentence_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// checksummed_sentence_parser
// Parses '$BODY*HH\n' sentences one byte per item, checks the XOR checksum,
// decodes the COO/HIT/CHA/DET IDs and up to three decimal fields.
// ----------------------------------------------------------------------------
// Every input item yields exactly one result item. An accepted byte sits in
// an input register, the parse update and the result are formed from it and
// the frame registers, and the result lands in the output register, so one
// item can be taken every cycle as long as results are taken. A stalled
// output stalls the input register and then in_ready. Bodies longer than
// MAX_BODY_LEN bytes fail; hex digits of either case are accepted.
module checksummed_sentence_parser #(
  parameter int MAX_BODY_LEN = csp_pkg::MAX_BODY_LEN_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [csp_pkg::BYTE_W-1:0]   in_byte_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [csp_pkg::STAT_W-1:0]        out_status,
  output logic [csp_pkg::FIELD_W-1:0]       out_field_a,
  output logic [csp_pkg::FIELD_W-1:0]       out_field_b,
  output logic [csp_pkg::FIELD_W-1:0]       out_field_c
);

  localparam int LEN_W = $clog2(MAX_BODY_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BODY_LEN);
  localparam logic [LEN_W-1:0] LEN_ID  = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  logic                         s1_vld_r;
  logic [csp_pkg::BYTE_W-1:0]   s1_byte_r;
  logic                         advance;

  csp_pkg::mode_t               mode_r, mode_nxt;
  logic [LEN_W-1:0]             len_r, len_nxt;
  logic [7:0]                   xor_r, xor_nxt;
  logic [7:0]                   rsum_r, rsum_nxt;
  logic [23:0]                  id_r, id_nxt;
  logic [1:0]                   fidx_r, fidx_nxt;
  logic [csp_pkg::FIELD_W-1:0]  fval_r [csp_pkg::NFIELDS];
  logic [csp_pkg::FIELD_W-1:0]  fval_nxt [csp_pkg::NFIELDS];
  logic [csp_pkg::NFIELDS-1:0]  fstop_r, fstop_nxt;
  logic                         infld_r, infld_nxt;

  csp_pkg::status_t             res_status;
  logic [csp_pkg::FIELD_W-1:0]  res_a, res_b, res_c;

  logic                         clr;
  logic [4:0]                   hv;
  logic [7:0]                   b;
  logic [csp_pkg::FIELD_W-1:0]  cur;
  logic [csp_pkg::FIELD_W-1:0]  digit;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte_in;
    end
  end

  always_comb begin
    b          = s1_byte_r;
    hv         = csp_pkg::hex_value(b);
    cur        = fval_r[fidx_r];
    digit      = csp_pkg::FIELD_W'(b - csp_pkg::CH_ZERO);
    mode_nxt   = mode_r;
    len_nxt    = len_r;
    xor_nxt    = xor_r;
    rsum_nxt   = rsum_r;
    id_nxt     = id_r;
    fidx_nxt   = fidx_r;
    fval_nxt   = fval_r;
    fstop_nxt  = fstop_r;
    infld_nxt  = infld_r;
    clr        = 1'b0;
    res_status = csp_pkg::ST_GOOD;
    res_a      = '0;
    res_b      = '0;
    res_c      = '0;

    unique case (mode_r)
      csp_pkg::MODE_WAIT: begin
        if (b == csp_pkg::CH_DOLLAR) begin
          clr      = 1'b1;
          mode_nxt = csp_pkg::MODE_BODY;
        end else begin
          res_status = csp_pkg::ST_WAITING;
        end
      end
      csp_pkg::MODE_BODY: begin
        if (b == csp_pkg::CH_STAR) begin
          mode_nxt = csp_pkg::MODE_HEX_HI;
        end else if (len_r >= LEN_MAX) begin
          res_status = csp_pkg::ST_FAIL;
          clr        = 1'b1;
          mode_nxt   = csp_pkg::MODE_WAIT;
        end else begin
          len_nxt = len_r + LEN_ONE;
          xor_nxt = xor_r ^ b;
          if (len_r < LEN_ID) begin
            id_nxt = {id_r[15:0], b};
          end
          if (!infld_r) begin
            if (b == csp_pkg::CH_COMMA) begin
              infld_nxt = 1'b1;
            end
          end else if (b == csp_pkg::CH_COMMA) begin
            if (fidx_r < 2'd2) begin
              fidx_nxt = fidx_r + 2'd1;
            end else begin
              fstop_nxt[2] = 1'b1;
            end
          end else if (!fstop_r[fidx_r]) begin
            if (b >= csp_pkg::CH_ZERO && b <= csp_pkg::CH_NINE) begin
              fval_nxt[fidx_r] = {cur[12:0], 3'b000} + {cur[14:0], 1'b0} + digit;
            end else begin
              fstop_nxt[fidx_r] = 1'b1;
            end
          end
        end
      end
      csp_pkg::MODE_HEX_HI: begin
        if (hv[4]) begin
          res_status = csp_pkg::ST_FAIL;
          clr        = 1'b1;
          mode_nxt   = csp_pkg::MODE_WAIT;
        end else begin
          rsum_nxt = {hv[3:0], 4'h0};
          mode_nxt = csp_pkg::MODE_HEX_LO;
        end
      end
      csp_pkg::MODE_HEX_LO: begin
        if (hv[4] || {rsum_r[7:4], hv[3:0]} != xor_r) begin
          res_status = csp_pkg::ST_FAIL;
          clr        = 1'b1;
          mode_nxt   = csp_pkg::MODE_WAIT;
        end else begin
          rsum_nxt = {rsum_r[7:4], hv[3:0]};
          mode_nxt = csp_pkg::MODE_NEWLINE;
        end
      end
      csp_pkg::MODE_NEWLINE: begin
        clr      = 1'b1;
        mode_nxt = csp_pkg::MODE_WAIT;
        if (b != csp_pkg::CH_NL || len_r < LEN_ID) begin
          res_status = csp_pkg::ST_FAIL;
        end else if (id_r == csp_pkg::ID_COO) begin
          res_status = csp_pkg::ST_COO;
        end else if (id_r == csp_pkg::ID_HIT) begin
          res_status = csp_pkg::ST_HIT;
        end else if (id_r == csp_pkg::ID_CHA) begin
          res_status = csp_pkg::ST_CHA;
        end else if (id_r == csp_pkg::ID_DET) begin
          res_status = csp_pkg::ST_DET;
        end else begin
          res_status = csp_pkg::ST_FAIL;
        end
        if (res_status != csp_pkg::ST_FAIL) begin
          res_a = fval_r[0];
          res_b = fval_r[1];
          res_c = (res_status == csp_pkg::ST_HIT) ? fval_r[2] : '0;
        end
      end
      default: begin
        res_status = csp_pkg::ST_FAIL;
        clr        = 1'b1;
        mode_nxt   = csp_pkg::MODE_WAIT;
      end
    endcase

    if (clr) begin
      len_nxt   = '0;
      xor_nxt   = '0;
      rsum_nxt  = '0;
      id_nxt    = '0;
      fidx_nxt  = '0;
      fval_nxt  = '{default: '0};
      fstop_nxt = '0;
      infld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= csp_pkg::MODE_WAIT;
      len_r   <= '0;
      xor_r   <= '0;
      rsum_r  <= '0;
      id_r    <= '0;
      fidx_r  <= '0;
      fval_r  <= '{default: '0};
      fstop_r <= '0;
      infld_r <= 1'b0;
    end else if (s1_vld_r && advance) begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      rsum_r  <= rsum_nxt;
      id_r    <= id_nxt;
      fidx_r  <= fidx_nxt;
      fval_r  <= fval_nxt;
      fstop_r <= fstop_nxt;
      infld_r <= infld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && advance) begin
      out_status  <= res_status;
      out_field_a <= res_a;
      out_field_b <= res_b;
      out_field_c <= res_c;
    end
  end

endmodule
`default_nettype wire

/* rtl/csp_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csp_checker
// Port-level checks of the sentence parser, bound to the top level.
// ----------------------------------------------------------------------------
module csp_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [csp_pkg::STAT_W-1:0]   out_status,
  input wire logic [csp_pkg::FIELD_W-1:0]  out_field_a,
  input wire logic [csp_pkg::FIELD_W-1:0]  out_field_b,
  input wire logic [csp_pkg::FIELD_W-1:0]  out_field_c
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_field_a) && $stable(out_field_b) && $stable(out_field_c))
    else $error("stalled result item changed");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= csp_pkg::ST_DET)
    else $error("status code out of range");

  a_untyped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status <= csp_pkg::ST_FAIL
      |-> out_field_a == '0 && out_field_b == '0 && out_field_c == '0)
    else $error("fields nonzero on untyped status");

  a_field_c_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != csp_pkg::ST_HIT |-> out_field_c == '0)
    else $error("third field nonzero outside HIT");

  // A byte taken into an empty pipe shows a result after passing the input and output registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid && !$past(in_valid && in_ready)
      |=> ##1 out_valid)
    else $error("result item missing after accepted byte");

endmodule

bind checksummed_sentence_parser csp_checker u_csp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_status  (out_status),
  .out_field_a (out_field_a),
  .out_field_b (out_field_b),
  .out_field_c (out_field_c)
);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the sentence parser a short scripted byte stream, then randomized
// sentences with random content and damage, and line noise between them.
// The sender idles in bursts and the receiver stalls on its own pattern.
// Every result is checked field by field against the scripted result where a
// row gives one, else against a byte-level parser model kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import csp_pkg::*;

  localparam int BODY_LIMIT   = MAX_BODY_LEN_DEF;
  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] field_a;
    logic [FIELD_W-1:0] field_b;
    logic [FIELD_W-1:0] field_c;
  } sentence_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              has_result;
    sentence_result_t  result;
  } script_row_t;

  typedef enum int {
    DMG_NONE,
    DMG_SUM,
    DMG_HEX_HI,
    DMG_HEX_LO,
    DMG_NO_NEWLINE,
    DMG_CUT
  } damage_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic [BYTE_W-1:0]   in_byte_in = '0;
  logic                out_ready  = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [FIELD_W-1:0]  out_field_a;
  logic [FIELD_W-1:0]  out_field_b;
  logic [FIELD_W-1:0]  out_field_c;

  checksummed_sentence_parser #(
    .MAX_BODY_LEN(BODY_LIMIT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte_in (in_byte_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_field_a(out_field_a),
    .out_field_b(out_field_b),
    .out_field_c(out_field_c)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser model state
  mode_t              parse_state;
  int                 frame_len;
  logic [7:0]         frame_xor;
  logic [7:0]         frame_sum;
  logic [23:0]        frame_id;
  int                 field_idx;
  logic [FIELD_W-1:0] field_val [NFIELDS];
  bit                 field_stop [NFIELDS];
  bit                 in_field_list;

  sentence_result_t   result_q [$];
  script_row_t        pending_q [$];
  int                 fail_count = 0;
  int                 cycle_count = 0;
  int                 sentence_bytes = 0;
  int                 burst_left = 0;

  logic [23:0] known_ids [4] = '{ID_COO, ID_HIT, ID_CHA, ID_DET};

  script_row_t directed_rows [0:21] = '{
    {8'h00,     1'b1, ST_WAITING, 48'd0},
    {8'hFF,     1'b1, ST_WAITING, 48'd0},
    {CH_DOLLAR, 1'b1, ST_GOOD,    48'd0},
    {CH_STAR,   1'b1, ST_GOOD,    48'd0},
    {8'h67,     1'b1, ST_FAIL,    48'd0},
    {CH_DOLLAR, 1'b0, 51'd0},
    {CH_STAR,   1'b0, 51'd0},
    {8'h30,     1'b0, 51'd0},
    {8'h31,     1'b1, ST_FAIL,    48'd0},
    {CH_DOLLAR, 1'b0, 51'd0},
    {8'h44,     1'b0, 51'd0},
    {8'h45,     1'b0, 51'd0},
    {8'h54,     1'b0, 51'd0},
    {CH_STAR,   1'b0, 51'd0},
    {8'h35,     1'b0, 51'd0},
    {8'h35,     1'b0, 51'd0},
    {CH_NL,     1'b1, ST_DET,     48'd0},
    {CH_DOLLAR, 1'b0, 51'd0},
    {CH_STAR,   1'b0, 51'd0},
    {8'h30,     1'b0, 51'd0},
    {8'h30,     1'b0, 51'd0},
    {CH_NL,     1'b1, ST_FAIL,    48'd0}
  };

  function automatic logic [4:0] nibble_of(input logic [7:0] ch);
    logic [7:0] v;
    v = 8'h10;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      v = ch - CH_ZERO;
    end else if (ch >= CH_UA && ch <= CH_UF) begin
      v = ch - CH_UA + 8'd10;
    end else if (ch >= CH_LA && ch <= CH_LF) begin
      v = ch - CH_LA + 8'd10;
    end
    return v[4:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) begin
      return CH_ZERO + 8'(n);
    end
    return (lower ? CH_LA : CH_UA) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] ch;
    if ($urandom_range(0, 7) == 0) begin
      return ($urandom_range(0, 1) == 0) ? CH_DOLLAR : CH_NL;
    end
    do ch = 8'($urandom); while (ch == CH_STAR);
    return ch;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] ch;
    logic [4:0] nib;
    do begin
      ch  = 8'($urandom);
      nib = nibble_of(ch);
    end while (!nib[4]);
    return ch;
  endfunction

  task automatic clear_frame_model();
    frame_len     = 0;
    frame_xor     = '0;
    frame_sum     = '0;
    frame_id      = '0;
    field_idx     = 0;
    in_field_list = 1'b0;
    for (int i = 0; i < NFIELDS; i++) begin
      field_val[i]  = '0;
      field_stop[i] = 1'b0;
    end
  endtask

  task automatic parse_byte(input logic [7:0] ch, output sentence_result_t res);
    logic [4:0]  nib;
    int unsigned acc;
    bit          broken;
    res        = '0;
    res.status = ST_GOOD;
    broken     = 1'b0;
    case (parse_state)
      MODE_WAIT: begin
        if (ch == CH_DOLLAR) begin
          clear_frame_model();
          parse_state = MODE_BODY;
        end else begin
          res.status = ST_WAITING;
        end
      end
      MODE_BODY: begin
        if (ch == CH_STAR) begin
          parse_state = MODE_HEX_HI;
        end else if (frame_len >= BODY_LIMIT) begin
          broken = 1'b1;
        end else begin
          frame_len++;
          frame_xor ^= ch;
          if (frame_len <= 3) frame_id = {frame_id[15:0], ch};
          if (!in_field_list) begin
            if (ch == CH_COMMA) in_field_list = 1'b1;
          end else if (ch == CH_COMMA) begin
            if (field_idx < NFIELDS - 1) field_idx++;
            else field_stop[NFIELDS-1] = 1'b1;
          end else if (!field_stop[field_idx]) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
              acc = field_val[field_idx] * 10 + (ch - CH_ZERO);
              field_val[field_idx] = acc[FIELD_W-1:0];
            end else begin
              field_stop[field_idx] = 1'b1;
            end
          end
        end
      end
      MODE_HEX_HI: begin
        nib = nibble_of(ch);
        if (nib[4]) begin
          broken = 1'b1;
        end else begin
          frame_sum   = {nib[3:0], 4'h0};
          parse_state = MODE_HEX_LO;
        end
      end
      MODE_HEX_LO: begin
        nib = nibble_of(ch);
        if (nib[4]) begin
          broken = 1'b1;
        end else begin
          frame_sum[3:0] = nib[3:0];
          if (frame_sum != frame_xor) broken = 1'b1;
          else parse_state = MODE_NEWLINE;
        end
      end
      MODE_NEWLINE: begin
        if (ch != CH_NL || frame_len < 3) begin
          broken = 1'b1;
        end else begin
          case (frame_id)
            ID_COO:  res.status = ST_COO;
            ID_HIT:  res.status = ST_HIT;
            ID_CHA:  res.status = ST_CHA;
            ID_DET:  res.status = ST_DET;
            default: broken = 1'b1;
          endcase
          if (!broken) begin
            res.field_a = field_val[0];
            res.field_b = field_val[1];
            res.field_c = (res.status == ST_HIT) ? field_val[2] : '0;
            clear_frame_model();
            parse_state = MODE_WAIT;
          end
        end
      end
      default: broken = 1'b1;
    endcase
    if (broken) begin
      clear_frame_model();
      parse_state = MODE_WAIT;
      res         = '0;
      res.status  = ST_FAIL;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Predict on input handshakes, check on output handshakes.
  always @(posedge clk) begin
    script_row_t      row;
    sentence_result_t want;
    sentence_result_t got;
    if (!rst_n) begin
      parse_state = MODE_WAIT;
      clear_frame_model();
    end else begin
      if (in_valid && in_ready) begin
        row = pending_q.pop_front();
        parse_byte(in_byte_in, want);
        if (row.has_result) want = row.result;
        result_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {out_status, out_field_a, out_field_b, out_field_c};
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= PRINT_LIMIT) begin
            $display("%0t: result with none expected, status %0d", $time, out_status);
          end
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status) flag_mismatch("status", want.status, got.status);
          if (got.field_a !== want.field_a) flag_mismatch("field_a", want.field_a, got.field_a);
          if (got.field_b !== want.field_b) flag_mismatch("field_b", want.field_b, got.field_b);
          if (got.field_c !== want.field_c) flag_mismatch("field_c", want.field_c, got.field_c);
        end
      end
    end
  end

  // Receiver stalls on a rotating pattern that is redrawn now and then.
  logic [15:0] stall_pattern = 16'hFFFF;
  int          pattern_age = 0;

  always @(posedge clk) begin
    if (pattern_age == 0) begin
      pattern_age = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0:       stall_pattern = 16'hFFFF;
        1:       stall_pattern = 16'($urandom) | 16'($urandom);
        default: stall_pattern = 16'($urandom);
      endcase
      if (stall_pattern == 16'h0000) stall_pattern = 16'h0001;
    end
    pattern_age--;
    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    out_ready <= stall_pattern[0];
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic has_result,
                           input sentence_result_t result);
    script_row_t row;
    int          gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    row.ch         = ch;
    row.has_result = has_result;
    row.result     = result;
    pending_q.push_back(row);
    in_valid   <= 1'b1;
    in_byte_in <= ch;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_sentence();
    logic [7:0]  frame [$];
    logic [7:0]  sum;
    logic [7:0]  ch;
    logic [23:0] id;
    damage_t     damage;
    int          pick;
    int          nchars;
    int          nfields;
    int          pad_to;
    frame = {};
    frame.push_back(CH_DOLLAR);
    pick = $urandom_range(0, 11);
    if (pick == 0) begin
      nchars = $urandom_range(0, 2);
      repeat (nchars) frame.push_back(CH_UA + 8'($urandom_range(0, 25)));
    end else begin
      if (pick == 1) begin
        id = {CH_UA + 8'($urandom_range(0, 25)), CH_UA + 8'($urandom_range(0, 25)),
              CH_UA + 8'($urandom_range(0, 25))};
      end else if (pick == 2) begin
        id = 24'($urandom);
      end else begin
        id = known_ids[$urandom_range(0, 3)];
      end
      frame.push_back(id[23:16]);
      frame.push_back(id[15:8]);
      frame.push_back(id[7:0]);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) frame.push_back(junk_byte());
      end
      if ($urandom_range(0, 9) != 0) begin
        frame.push_back(CH_COMMA);
        nfields = $urandom_range(0, 5);
        for (int f = 0; f < nfields; f++) begin
          if (f > 0) frame.push_back(CH_COMMA);
          nchars = ($urandom_range(0, 6) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
          repeat (nchars) begin
            if ($urandom_range(0, 9) == 0) frame.push_back(junk_byte());
            else frame.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end
        end
      end
    end
    if ($urandom_range(0, 11) == 0) begin
      pad_to = $urandom_range(BODY_LIMIT - 2, BODY_LIMIT + 2);
      while (frame.size() < pad_to + 1) begin
        if ($urandom_range(0, 3) == 0) frame.push_back(junk_byte());
        else frame.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
    end
    sum = '0;
    for (int i = 1; i < frame.size(); i++) sum ^= frame[i];
    pick   = $urandom_range(0, 13);
    damage = (pick > 5) ? DMG_NONE : damage_t'(pick);
    if (damage == DMG_SUM) sum ^= 8'(1 << $urandom_range(0, 7));
    if (damage != DMG_CUT) begin
      frame.push_back(CH_STAR);
      if (damage == DMG_HEX_HI) frame.push_back(bad_hex_char());
      else frame.push_back(hex_char(sum[7:4], $urandom_range(0, 1)));
      if (damage == DMG_HEX_LO) frame.push_back(bad_hex_char());
      else frame.push_back(hex_char(sum[3:0], $urandom_range(0, 1)));
      if (damage == DMG_NO_NEWLINE) begin
        do ch = 8'($urandom); while (ch == CH_NL);
        frame.push_back(ch);
      end else begin
        frame.push_back(CH_NL);
      end
    end
    foreach (frame[i]) send_item(frame[i], 1'b0, '0);
    sentence_bytes += frame.size();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].ch, directed_rows[i].has_result, directed_rows[i].result);
    end
    while (sentence_bytes < RANDOM_ITEMS) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) send_item(8'($urandom), 1'b0, '0);
      end else begin
        send_sentence();
      end
    end
    in_valid <= 1'b0;
    while (result_q.size() != 0 || pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
